// File: hw/rtl/block_cache_least_read_family_unit_macros.svh
// assertion macros shared by the checker of the block cache policy unit
// no dependencies; included by files that hold concurrent assertions
`ifndef BLOCK_CACHE_LEAST_READ_FAMILY_UNIT_MACROS_SVH
`define BLOCK_CACHE_LEAST_READ_FAMILY_UNIT_MACROS_SVH

// same-cycle implication, off while reset is high
`define BCLRF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bclrf same-cycle check failed");

// next-cycle implication, off while reset is high
`define BCLRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bclrf next-cycle check failed");

// next-cycle implication that also holds through reset
`define BCLRF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("bclrf reset check failed");

`endif

// File: hw/rtl/bclrf_pkg.sv
// types and constants of the block cache policy unit
// no dependencies; used by controller, datapath and top level
`default_nettype none

package bclrf_pkg;

   localparam int BLOCK_W = 24;
   localparam int OFF_W   = 6;                 // 64 blocks per family
   localparam int TAG_W   = BLOCK_W - OFF_W;
   localparam int SLOT_W  = 12;
   localparam int TOTAL_W = 16;
   localparam int CMD_W   = 2;

   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SYNC  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [TOTAL_W-1:0] total;
      logic               dirty;
   } entry_type;

   typedef struct packed {
      logic load;     // capture the request
      logic step;     // run the family scan
      logic commit;   // update the table and present the result
   } ctl_cmd_type;

   typedef struct packed {
      logic req_null;   // offered request carries the unused command
      logic scan_done;  // every needed family entry has been seen
      logic out_free;   // result register can take a new transaction
   } dp_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/bclrf_ctrl.sv
// sequencing state machine of the block cache policy unit
// depends on bclrf_pkg; drives the datapath by command struct
`default_nettype none

module bclrf_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire bclrf_pkg::dp_status_type status,
   output bclrf_pkg::ctl_cmd_type      ctl
);

   bclrf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bclrf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      ctl        = '0;
      case (state_ff)
         bclrf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               if (!status.req_null) begin
                  state_in = bclrf_pkg::ST_SCAN;
               end
            end
         end
         bclrf_pkg::ST_SCAN: begin
            ctl.step = 1'b1;
            if (status.scan_done) begin
               state_in = bclrf_pkg::ST_COMMIT;
            end
         end
         bclrf_pkg::ST_COMMIT: begin
            if (status.out_free) begin
               ctl.commit = 1'b1;
               state_in   = bclrf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bclrf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/bclrf_dp.sv
// datapath of the block cache policy unit: family table memory, scan, result register
// depends on bclrf_pkg; controlled by bclrf_ctrl
`default_nettype none

module bclrf_dp #(
   parameter int NUM_FAMILIES = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [bclrf_pkg::CMD_W-1:0]        req_command,
   input  wire logic [bclrf_pkg::BLOCK_W-1:0]      req_block_id,
   input  wire bclrf_pkg::ctl_cmd_type             ctl,
   output bclrf_pkg::dp_status_type                status,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_hit,
   output logic [bclrf_pkg::SLOT_W-1:0]            rsp_slot,
   output logic                                    rsp_fetch_needed,
   output logic [bclrf_pkg::BLOCK_W-1:0]           rsp_fetch_block,
   output logic                                    rsp_writeback_needed,
   output logic [bclrf_pkg::BLOCK_W-1:0]           rsp_writeback_block,
   output logic                                    rsp_last
);

   localparam int IDX_W  = $clog2(NUM_FAMILIES);
   localparam int FILL_W = $clog2(NUM_FAMILIES + 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(NUM_FAMILIES);
   localparam int OFF_W = bclrf_pkg::OFF_W;
   localparam int TAG_W = bclrf_pkg::TAG_W;

   // family table: tag, read total and dirty mark in one word
   bclrf_pkg::entry_type table_mem [NUM_FAMILIES];

   logic [bclrf_pkg::CMD_W-1:0] cmd_ff;
   logic [TAG_W-1:0]            tag_ff;
   logic [OFF_W-1:0]            off_ff;
   logic [FILL_W-1:0]           fill_ff;     // families 0 .. fill-1 are loaded
   logic [FILL_W-1:0]           issue_ff;
   logic                        pend_ff;
   logic [IDX_W-1:0]            pend_idx_ff;
   bclrf_pkg::entry_type        rdata_ff;
   logic                        found_ff;
   logic [IDX_W-1:0]            hit_idx_ff;
   bclrf_pkg::entry_type        hit_ent_ff;
   logic [IDX_W-1:0]            best_idx_ff;
   bclrf_pkg::entry_type        best_ent_ff;
   logic                        any_ff;
   logic [TAG_W-1:0]            last_tag_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   logic [bclrf_pkg::SLOT_W-1:0]  rsp_slot_ff;
   logic                        rsp_fetch_ff;
   logic [bclrf_pkg::BLOCK_W-1:0] rsp_fetch_block_ff;
   logic                        rsp_wb_ff;
   logic [bclrf_pkg::BLOCK_W-1:0] rsp_wb_block_ff;

   logic                        is_sync;
   logic                        is_write;
   logic                        rd_en;
   logic                        proc;
   logic                        match;
   logic                        better;
   logic                        table_full;
   logic [IDX_W-1:0]            fam_sel;
   bclrf_pkg::entry_type        base_ent;
   bclrf_pkg::entry_type        new_ent;
   logic                        victim_wb;
   logic                        we;
   logic [IDX_W-1:0]            waddr;
   bclrf_pkg::entry_type        wdata;

   always_comb begin
      is_sync    = (cmd_ff == bclrf_pkg::CMD_SYNC);
      is_write   = (cmd_ff == bclrf_pkg::CMD_WRITE);
      table_full = (fill_ff == FILL_FULL);
      rd_en      = ctl.step && !found_ff && (issue_ff != fill_ff);
      proc       = ctl.step && pend_ff && !found_ff;
      match      = proc && !is_sync && (rdata_ff.tag == tag_ff);
      better     = proc && ((pend_idx_ff == '0) || (rdata_ff.total < best_ent_ff.total));

      status.req_null  = (req_command == bclrf_pkg::CMD_NONE);
      status.scan_done = !pend_ff && (found_ff || (issue_ff == fill_ff));
      status.out_free  = !rsp_valid_ff || rsp_ready;

      // target family: hit, first empty one, or least read one
      if (found_ff) begin
         fam_sel = hit_idx_ff;
      end else if (!table_full) begin
         fam_sel = fill_ff[IDX_W-1:0];
      end else begin
         fam_sel = best_idx_ff;
      end

      if (found_ff) begin
         base_ent = hit_ent_ff;
      end else begin
         base_ent.tag   = tag_ff;
         base_ent.total = '0;
         base_ent.dirty = 1'b0;
      end
      new_ent = base_ent;
      if (is_write) begin
         new_ent.dirty = 1'b1;
      end else if (base_ent.total != '1) begin
         new_ent.total = base_ent.total + 1'b1;
      end

      victim_wb = !found_ff && table_full && best_ent_ff.dirty;

      // sync clears dirty marks on the fly; access updates at commit
      we    = 1'b0;
      waddr = fam_sel;
      wdata = new_ent;
      if (proc && is_sync && rdata_ff.dirty) begin
         we          = 1'b1;
         waddr       = pend_idx_ff;
         wdata       = rdata_ff;
         wdata.dirty = 1'b0;
      end else if (ctl.commit && !is_sync) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         table_mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= table_mem[issue_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= rd_en;
         if (ctl.commit && !is_sync && !found_ff && !table_full) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (ctl.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_command;
         tag_ff   <= req_block_id[bclrf_pkg::BLOCK_W-1:OFF_W];
         off_ff   <= req_block_id[OFF_W-1:0];
         issue_ff <= '0;
         found_ff <= 1'b0;
         any_ff   <= 1'b0;
      end else begin
         if (rd_en) begin
            issue_ff    <= issue_ff + 1'b1;
            pend_idx_ff <= issue_ff[IDX_W-1:0];
         end
         if (match) begin
            found_ff   <= 1'b1;
            hit_idx_ff <= pend_idx_ff;
            hit_ent_ff <= rdata_ff;
         end
         if (better) begin
            best_idx_ff <= pend_idx_ff;
            best_ent_ff <= rdata_ff;
         end
         if (proc && is_sync && rdata_ff.dirty) begin
            any_ff      <= 1'b1;
            last_tag_ff <= rdata_ff.tag;
         end
      end

      if (ctl.commit) begin
         if (is_sync) begin
            rsp_hit_ff         <= 1'b0;
            rsp_slot_ff        <= '0;
            rsp_fetch_ff       <= 1'b0;
            rsp_fetch_block_ff <= '0;
            rsp_wb_ff          <= any_ff;
            rsp_wb_block_ff    <= any_ff ? {last_tag_ff, {OFF_W{1'b0}}} : '0;
         end else begin
            rsp_hit_ff         <= found_ff;
            rsp_slot_ff        <= (bclrf_pkg::SLOT_W'(fam_sel) << OFF_W)
                                  | bclrf_pkg::SLOT_W'(off_ff);
            rsp_fetch_ff       <= !found_ff;
            rsp_fetch_block_ff <= found_ff ? '0 : {tag_ff, {OFF_W{1'b0}}};
            rsp_wb_ff          <= victim_wb;
            rsp_wb_block_ff    <= victim_wb ? {best_ent_ff.tag, {OFF_W{1'b0}}} : '0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_fetch_needed     = rsp_fetch_ff;
   assign rsp_fetch_block      = rsp_fetch_block_ff;
   assign rsp_writeback_needed = rsp_wb_ff;
   assign rsp_writeback_block  = rsp_wb_block_ff;
   assign rsp_last             = 1'b1;

endmodule

`default_nettype wire

// File: hw/rtl/block_cache_least_read_family_unit.sv
// top level of the block cache policy unit: family tags and least-read replacement
// depends on bclrf_pkg, bclrf_ctrl and bclrf_dp
//
// usage
//   req channel (req_valid/req_ready): one transaction carries a command and a
//   block id. read and write look up the block's 64-block family; sync reports
//   the highest dirty family and clears every dirty mark. the unused command is
//   taken and gives no result. rsp channel (rsp_valid/rsp_ready): exactly one
//   result transaction per read, write or sync, always with rsp_last high.
// timing
//   one transaction at a time; with F loaded families (0 .. NUM_FAMILIES)
//   the scan reads them in order, and a hit ends the scan one entry past the
//   match. the table is read one family entry per cycle while scanning. the
//   next request is taken the cycle after commit.
// reset
//   synchronous, active high; the loaded-family count and all handshake state
//   clear at once, so no clearing pass is needed. table words are written
//   when a family is first loaded and are never read before that.
// stall
//   a finished result waits in the output register; the next request is
//   accepted and scanned meanwhile, and only its commit waits for rsp_ready.
`default_nettype none

module block_cache_least_read_family_unit #(
   parameter int NUM_FAMILIES = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [bclrf_pkg::CMD_W-1:0]       req_command,
   input  wire logic [bclrf_pkg::BLOCK_W-1:0]     req_block_id,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_hit,
   output logic [bclrf_pkg::SLOT_W-1:0]           rsp_slot,
   output logic                                   rsp_fetch_needed,
   output logic [bclrf_pkg::BLOCK_W-1:0]          rsp_fetch_block,
   output logic                                   rsp_writeback_needed,
   output logic [bclrf_pkg::BLOCK_W-1:0]          rsp_writeback_block,
   output logic                                   rsp_last
);

   // command and status between sequencer and datapath
   bclrf_pkg::ctl_cmd_type   ctl;
   bclrf_pkg::dp_status_type status;

   // sequencer: idle / scan / commit
   bclrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .ctl       (ctl)
   );

   // family table, victim search and result register
   bclrf_dp #(
      .NUM_FAMILIES (NUM_FAMILIES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_command          (req_command),
      .req_block_id         (req_block_id),
      .ctl                  (ctl),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_hit              (rsp_hit),
      .rsp_slot             (rsp_slot),
      .rsp_fetch_needed     (rsp_fetch_needed),
      .rsp_fetch_block      (rsp_fetch_block),
      .rsp_writeback_needed (rsp_writeback_needed),
      .rsp_writeback_block  (rsp_writeback_block),
      .rsp_last             (rsp_last)
   );

endmodule

`default_nettype wire

// File: hw/rtl/bclrf_checker.sv
// port-level checks of the block cache policy unit, bound to its top level
// depends on bclrf_pkg and block_cache_least_read_family_unit_macros.svh
`default_nettype none
`include "block_cache_least_read_family_unit_macros.svh"

module bclrf_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic [bclrf_pkg::CMD_W-1:0]       req_command,
   input wire logic [bclrf_pkg::BLOCK_W-1:0]     req_block_id,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic                              rsp_hit,
   input wire logic [bclrf_pkg::SLOT_W-1:0]      rsp_slot,
   input wire logic                              rsp_fetch_needed,
   input wire logic [bclrf_pkg::BLOCK_W-1:0]     rsp_fetch_block,
   input wire logic                              rsp_writeback_needed,
   input wire logic [bclrf_pkg::BLOCK_W-1:0]     rsp_writeback_block,
   input wire logic                              rsp_last
);

   logic                                            req_stall;
   logic [bclrf_pkg::CMD_W+bclrf_pkg::BLOCK_W-1:0]  req_word;
   logic                                            rsp_stall;
   logic [2*bclrf_pkg::BLOCK_W+bclrf_pkg::SLOT_W+3:0] rsp_word;
   logic                                            rsp_quiet;
   logic                                            rsp_plain;
   logic                                            rsp_no_addr;

   assign req_stall   = req_valid && !req_ready;
   assign req_word    = {req_command, req_block_id};
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_word    = {rsp_hit, rsp_slot, rsp_fetch_needed, rsp_fetch_block,
                         rsp_writeback_needed, rsp_writeback_block, rsp_last};
   assign rsp_quiet   = !rsp_fetch_needed && !rsp_writeback_needed && rsp_last;
   assign rsp_plain   = rsp_valid && !rsp_writeback_needed && !rsp_fetch_needed;
   assign rsp_no_addr = (rsp_writeback_block == '0) && (rsp_fetch_block == '0);

   // a waiting request holds
   `BCLRF_ASSERT_NEXT(a_req_hold, clock, reset, req_stall, req_valid && $stable(req_word))

   // a stalled result holds
   `BCLRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

   // a hit needs neither fetch nor write-back
   `BCLRF_ASSERT_IMPL(a_hit_quiet, clock, reset, rsp_valid && rsp_hit, rsp_quiet)

   // no write-back and no fetch means zero addresses
   `BCLRF_ASSERT_IMPL(a_zero_addr, clock, reset, rsp_plain, rsp_no_addr)

   // nothing is offered right after reset
   `BCLRF_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid)

endmodule

bind block_cache_least_read_family_unit bclrf_checker u_bclrf_checker (.*);

`default_nettype wire

// File: verif/tb_block_cache_least_read_family_unit.sv
// self-checking testbench for the block cache family tag and least-read replacement unit
// depends on bclrf_pkg and block_cache_least_read_family_unit; predicts every result in-line
`timescale 1ns / 100ps

module tb_block_cache_least_read_family_unit;

   localparam int BLOCK_W           = bclrf_pkg::BLOCK_W;
   localparam int OFF_W             = bclrf_pkg::OFF_W;
   localparam int TAG_W             = bclrf_pkg::TAG_W;
   localparam int SLOT_W            = bclrf_pkg::SLOT_W;
   localparam int TOTAL_W           = bclrf_pkg::TOTAL_W;
   localparam int CMD_W             = bclrf_pkg::CMD_W;
   localparam int NUM_FAMILIES      = 64;
   localparam int BLOCKS_PER_FAMILY = 1 << OFF_W;
   localparam int RANDOM_ITEMS      = 112;
   localparam int IDLE_LIMIT        = 2000;             // cycles with no transaction at all
   localparam int TAIL_CYCLES       = NUM_FAMILIES + 8; // one full scan plus commit slack
   localparam int READ_RUN          = 4;                // short run of reads on one family

   // one result transaction, field for field as on the rsp_ ports
   typedef struct packed {
      logic                 hit;
      logic [SLOT_W-1:0]    slot;
      logic                 fetch_needed;
      logic [BLOCK_W-1:0]   fetch_block;
      logic                 writeback_needed;
      logic [BLOCK_W-1:0]   writeback_block;
      logic                 last;
   } lookup_type;

   // one directed row: command, block, repeat count and an optional typed-in answer
   typedef struct {
      logic [CMD_W-1:0]     cmd;
      logic [BLOCK_W-1:0]   blk;
      int unsigned          repeats;
      bit                   typed;
      lookup_type           want;
   } stim_row_type;

   typedef enum logic [1:0] {
      RCV_OPEN,
      RCV_RANDOM,
      RCV_PATTERN,
      RCV_SLOW
   } rcv_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_command = bclrf_pkg::CMD_READ;
   logic [BLOCK_W-1:0]   req_block_id = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_hit;
   logic [SLOT_W-1:0]    rsp_slot;
   logic                 rsp_fetch_needed;
   logic [BLOCK_W-1:0]   rsp_fetch_block;
   logic                 rsp_writeback_needed;
   logic [BLOCK_W-1:0]   rsp_writeback_block;
   logic                 rsp_last;

   // typed-in answer travelling with the request currently offered
   bit                   req_typed = 1'b0;
   lookup_type           req_want = '0;

   // shadow copy of the family table
   bit [TAG_W-1:0]       fam_tag    [NUM_FAMILIES];
   bit                   fam_loaded [NUM_FAMILIES];
   bit [TOTAL_W-1:0]     fam_reads  [NUM_FAMILIES];
   bit                   fam_dirty  [NUM_FAMILIES];

   lookup_type           outstanding_lookups[$];
   stim_row_type         directed_rows[$];
   logic [TAG_W-1:0]     recent_tags[$];
   int                   mismatch_count = 0;
   int                   idle_cycles = 0;
   int                   burst_left = 0;

   block_cache_least_read_family_unit #(
      .NUM_FAMILIES(NUM_FAMILIES)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_block_id         (req_block_id),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_hit              (rsp_hit),
      .rsp_slot             (rsp_slot),
      .rsp_fetch_needed     (rsp_fetch_needed),
      .rsp_fetch_block      (rsp_fetch_block),
      .rsp_writeback_needed (rsp_writeback_needed),
      .rsp_writeback_block  (rsp_writeback_block),
      .rsp_last             (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic lookup_type answer(input logic hit, input int slot, input logic fetch,
                                         input logic [BLOCK_W-1:0] fetch_blk, input logic wb,
                                         input logic [BLOCK_W-1:0] wb_blk);
      lookup_type r;
      r.hit              = hit;
      r.slot             = SLOT_W'(slot);
      r.fetch_needed     = fetch;
      r.fetch_block      = fetch_blk;
      r.writeback_needed = wb;
      r.writeback_block  = wb_blk;
      r.last             = 1'b1;
      return r;
   endfunction

   // advance the shadow table by one request; returns 0 when the request gives no result
   function automatic bit predict_lookup(input logic [CMD_W-1:0] cmd,
                                         input logic [BLOCK_W-1:0] blk, output lookup_type r);
      logic [TAG_W-1:0] tag;
      logic [OFF_W-1:0] off;
      int               fam;
      bit               found;
      r      = '0;
      r.last = 1'b1;
      tag    = blk[BLOCK_W-1:OFF_W];
      off    = blk[OFF_W-1:0];
      if (cmd == bclrf_pkg::CMD_NONE) begin
         return 1'b0;
      end
      if (cmd == bclrf_pkg::CMD_SYNC) begin
         // highest dirty family wins the report, every mark goes away
         for (int i = 0; i < NUM_FAMILIES; i++) begin
            if (fam_loaded[i] && fam_dirty[i]) begin
               r.writeback_needed = 1'b1;
               r.writeback_block  = {fam_tag[i], {OFF_W{1'b0}}};
            end
            fam_dirty[i] = 1'b0;
         end
         return 1'b1;
      end
      found = 1'b0;
      fam   = 0;
      for (int i = 0; i < NUM_FAMILIES && !found; i++) begin
         if (fam_loaded[i] && fam_tag[i] == tag) begin
            found = 1'b1;
            fam   = i;
         end
      end
      if (!found) begin
         // victim: first empty family, else least read total, lowest index on ties
         fam = -1;
         for (int i = 0; i < NUM_FAMILIES; i++) begin
            if (!fam_loaded[i] && fam < 0) fam = i;
         end
         if (fam < 0) begin
            fam = 0;
            for (int i = 1; i < NUM_FAMILIES; i++) begin
               if (fam_reads[i] < fam_reads[fam]) fam = i;
            end
         end
         if (fam_loaded[fam] && fam_dirty[fam]) begin
            r.writeback_needed = 1'b1;
            r.writeback_block  = {fam_tag[fam], {OFF_W{1'b0}}};
         end
         fam_tag[fam]    = tag;
         fam_loaded[fam] = 1'b1;
         fam_reads[fam]  = '0;
         fam_dirty[fam]  = 1'b0;
         r.fetch_needed  = 1'b1;
         r.fetch_block   = {tag, {OFF_W{1'b0}}};
      end
      if (cmd == bclrf_pkg::CMD_WRITE) begin
         fam_dirty[fam] = 1'b1;
      end else if (fam_reads[fam] != '1) begin
         fam_reads[fam] = fam_reads[fam] + 1'b1;
      end
      r.hit  = found;
      r.slot = SLOT_W'(fam * BLOCKS_PER_FAMILY + off);
      return 1'b1;
   endfunction

   task automatic flag_mismatch(input string what, input logic [BLOCK_W-1:0] got,
                                input logic [BLOCK_W-1:0] want);
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // offer one request transaction; the sender may idle between bursts of random length
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [BLOCK_W-1:0] blk,
                               input bit typed, input lookup_type want);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 10);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_block_id <= blk;
      req_typed    <= typed;
      req_want     <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // receiver: whenever the 6-bit phase counter wraps, pick how rsp_ready behaves for the next stretch
   always @(posedge clock) begin
      static rcv_mode_type rcv_mode = RCV_OPEN;
      static logic [7:0]   rcv_mask = 8'hff;
      static logic [5:0]   rcv_phase = '0;
      if (rcv_phase == '0) begin
         rcv_mode = rcv_mode_type'($urandom_range(0, 3));
         rcv_mask = 8'($urandom) | 8'h01;
      end
      rcv_phase = rcv_phase + 1'b1;
      case (rcv_mode)
         RCV_OPEN: begin
            rsp_ready <= 1'b1;
         end
         RCV_RANDOM: begin
            rsp_ready <= ($urandom_range(0, 9) < 7);
         end
         RCV_PATTERN: begin
            rsp_ready <= rcv_mask[rcv_phase[2:0]];
         end
         default: begin
            rsp_ready <= (rcv_phase[2:0] == 3'd0);
         end
      endcase
   end

   // checker: results first, so a result and a request at the same edge stay in order
   always @(posedge clock) begin
      lookup_type got;
      lookup_type want;
      lookup_type predicted;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_hit, rsp_slot, rsp_fetch_needed, rsp_fetch_block,
                   rsp_writeback_needed, rsp_writeback_block, rsp_last};
            if (outstanding_lookups.size() == 0) begin
               flag_mismatch("result with nothing outstanding", BLOCK_W'(got.slot), '0);
            end else begin
               want = outstanding_lookups.pop_front();
               if (got.hit !== want.hit)
                  flag_mismatch("hit", BLOCK_W'(got.hit), BLOCK_W'(want.hit));
               if (got.slot !== want.slot)
                  flag_mismatch("slot", BLOCK_W'(got.slot), BLOCK_W'(want.slot));
               if (got.fetch_needed !== want.fetch_needed)
                  flag_mismatch("fetch_needed", BLOCK_W'(got.fetch_needed),
                                BLOCK_W'(want.fetch_needed));
               if (got.fetch_block !== want.fetch_block)
                  flag_mismatch("fetch_block", got.fetch_block, want.fetch_block);
               if (got.writeback_needed !== want.writeback_needed)
                  flag_mismatch("writeback_needed", BLOCK_W'(got.writeback_needed),
                                BLOCK_W'(want.writeback_needed));
               if (got.writeback_block !== want.writeback_block)
                  flag_mismatch("writeback_block", got.writeback_block,
                                want.writeback_block);
               if (got.last !== want.last)
                  flag_mismatch("last", BLOCK_W'(got.last), BLOCK_W'(want.last));
            end
         end
         if (req_valid && req_ready) begin
            // the shadow table always advances; a typed-in answer overrides its result
            if (predict_lookup(req_command, req_block_id, predicted)) begin
               outstanding_lookups.push_back(req_typed ? req_want : predicted);
            end
         end
      end
   end

   // watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      lookup_type         none;
      logic [CMD_W-1:0]   cmd;
      logic [BLOCK_W-1:0] blk;
      int                 pick;
      int                 counted;
      none = '0;

      // empty table: sync reports nothing, unused command gives no result
      directed_rows.push_back('{bclrf_pkg::CMD_SYNC, 24'h000000, 1, 1'b1,
                                answer(1'b0, 0, 1'b0, '0, 1'b0, '0)});
      directed_rows.push_back('{bclrf_pkg::CMD_NONE, 24'hffffff, 1, 1'b0, none});
      // first misses fill families 0 and 1, lowest and highest block ids
      directed_rows.push_back('{bclrf_pkg::CMD_READ, 24'h000000, 1, 1'b1,
                                answer(1'b0, 0, 1'b1, '0, 1'b0, '0)});
      directed_rows.push_back('{bclrf_pkg::CMD_READ, 24'hffffff, 1, 1'b1,
                                answer(1'b0, 127, 1'b1, 24'hffffc0, 1'b0, '0)});
      // write hits mark both families dirty
      directed_rows.push_back('{bclrf_pkg::CMD_WRITE, 24'hffffff, 1, 1'b1,
                                answer(1'b1, 127, 1'b0, '0, 1'b0, '0)});
      directed_rows.push_back('{bclrf_pkg::CMD_WRITE, 24'h00003f, 1, 1'b1,
                                answer(1'b1, 63, 1'b0, '0, 1'b0, '0)});
      // sync reports the highest dirty family, a second sync finds nothing left
      directed_rows.push_back('{bclrf_pkg::CMD_SYNC, 24'hffffff, 1, 1'b1,
                                answer(1'b0, 0, 1'b0, '0, 1'b1, 24'hffffc0)});
      directed_rows.push_back('{bclrf_pkg::CMD_SYNC, 24'h000000, 1, 1'b1,
                                answer(1'b0, 0, 1'b0, '0, 1'b0, '0)});
      // a short run of reads lifts the read total of family 0
      directed_rows.push_back('{bclrf_pkg::CMD_READ, 24'h000015, READ_RUN, 1'b0, none});
      directed_rows.push_back('{bclrf_pkg::CMD_WRITE, 24'habcdef, 1, 1'b1,
                                answer(1'b0, 175, 1'b1, 24'habcdc0, 1'b0, '0)});
      directed_rows.push_back('{bclrf_pkg::CMD_NONE, 24'h000000, 1, 1'b0, none});
      directed_rows.push_back('{bclrf_pkg::CMD_READ, 24'h555555, 1, 1'b0, none});
      directed_rows.push_back('{bclrf_pkg::CMD_WRITE, 24'haaaaaa, 1, 1'b0, none});
      directed_rows.push_back('{bclrf_pkg::CMD_READ, 24'habcdc0, 1, 1'b1,
                                answer(1'b1, 128, 1'b0, '0, 1'b0, '0)});
      directed_rows.push_back('{bclrf_pkg::CMD_SYNC, 24'h123456, 1, 1'b0, none});
      directed_rows.push_back('{bclrf_pkg::CMD_WRITE, 24'h000000, 1, 1'b1,
                                answer(1'b1, 0, 1'b0, '0, 1'b0, '0)});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         for (int n = 0; n < directed_rows[r].repeats; n++) begin
            send_request(directed_rows[r].cmd, directed_rows[r].blk,
                         directed_rows[r].typed, directed_rows[r].want);
         end
         if (directed_rows[r].cmd != bclrf_pkg::CMD_NONE &&
             directed_rows[r].cmd != bclrf_pkg::CMD_SYNC)
            recent_tags.push_back(directed_rows[r].blk[BLOCK_W-1:OFF_W]);
      end

      // random part: mostly accesses, about half to fresh families so the table fills
      // and evicts; the rest revisits recent families or the lowest or highest block, syncs or sends the unused command
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         cmd  = ($urandom_range(0, 1) == 0) ? bclrf_pkg::CMD_READ : bclrf_pkg::CMD_WRITE;
         blk  = 24'($urandom);
         if (pick < 4) begin
            cmd = bclrf_pkg::CMD_NONE;
         end else if (pick < 10) begin
            cmd = bclrf_pkg::CMD_SYNC;
         end else if (pick < 13) begin
            blk = ($urandom_range(0, 1) == 0) ? '0 : '1;
         end else if (pick < 50) begin
            blk = {recent_tags[$urandom_range(0, recent_tags.size() - 1)],
                   OFF_W'($urandom)};
         end
         if (cmd == bclrf_pkg::CMD_READ || cmd == bclrf_pkg::CMD_WRITE) begin
            recent_tags.push_back(blk[BLOCK_W-1:OFF_W]);
            if (recent_tags.size() > 96) void'(recent_tags.pop_front());
         end
         send_request(cmd, blk, 1'b0, none);
         if (cmd != bclrf_pkg::CMD_NONE) counted++;
      end
      req_valid <= 1'b0;

      // drain, then give the unit a full scan's time to show any stray result
      while (outstanding_lookups.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
